/* design/cia_pkg.sv */
// Shared constants for the checked integer ALU.
// No dependencies.
package cia_pkg;
  localparam int WIDTH_DEF = 32;
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;
  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd2;
endpackage

/* design/cia_cell.sv */
// One stage of the ALU pipeline: one multiply partial-product bit or one
// restoring division step. Depends on cia_pkg.
module cia_cell import cia_pkg::*; #(
  parameter int W = WIDTH_DEF,
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           v_i,
  input  logic [1:0]     mode_i,
  input  logic           sgn_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  input  logic [W-1:0]   ma_i,
  input  logic [W-1:0]   mb_i,
  input  logic [2*W-1:0] acc_i,
  input  logic [W-1:0]   rem_i,
  output logic           v_o,
  output logic [1:0]     mode_o,
  output logic           sgn_o,
  output logic [W-1:0]   a_o,
  output logic [W-1:0]   b_o,
  output logic [W-1:0]   ma_o,
  output logic [W-1:0]   mb_o,
  output logic [2*W-1:0] acc_o,
  output logic [W-1:0]   rem_o
);
  localparam int BI = W - 1 - IDX;
  logic [W:0]     trial;
  logic [W:0]     sh;
  logic [2*W-1:0] acc_nxt;
  logic [W-1:0]   rem_nxt;
  logic           v_r;
  logic [1:0]     mode_r;
  logic           sgn_r;
  logic [W-1:0]   a_r, b_r, ma_r, mb_r, rem_r;
  logic [2*W-1:0] acc_r;

  always_comb begin
    sh = {rem_i, ma_i[BI]};
    trial = sh - {1'b0, mb_i};
    acc_nxt = acc_i;
    rem_nxt = rem_i;
    if (mode_i == MODE_MUL) begin
      // add shifted multiplicand when this multiplier bit is set
      if (mb_i[IDX])
        acc_nxt = acc_i + ({{W{1'b0}}, ma_i} << IDX);
    end else begin
      // restoring division: one quotient bit per cell, MSB first
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        acc_nxt[BI] = 1'b1;
      end else begin
        rem_nxt = sh[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= v_i;
    mode_r <= mode_i;
    sgn_r <= sgn_i;
    a_r <= a_i;
    b_r <= b_i;
    ma_r <= ma_i;
    mb_r <= mb_i;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign v_o = v_r;
  assign mode_o = mode_r;
  assign sgn_o = sgn_r;
  assign a_o = a_r;
  assign b_o = b_r;
  assign ma_o = ma_r;
  assign mb_o = mb_r;
  assign acc_o = acc_r;
  assign rem_o = rem_r;
endmodule

/* design/checked_integer_alu_unit.sv */
// Top level of the checked integer ALU: operand prep, a chain of WIDTH
// cells, and the result/error stage. Depends on cia_pkg and cia_cell.
//
// Usage: drive in_mode, in_operand_a, in_operand_b and pulse start; busy
// is always low, so a word is taken every cycle start is high.
// Each word flows through a prep register, WIDTH cells (one multiplier
// bit or one quotient bit per cell) and an output register; throughput
// is one word per cycle. out_valid marks a result for exactly one cycle;
// the receiver cannot stall, so no result is held back.
// cfg_is_signed is written when cfg_valid is high (cfg_ready is always
// high); write it only while no word is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and sets signed mode.
// Errors: 1 overflow, 2 division by zero; on error out_result equals
// operand a.
module checked_integer_alu_unit import cia_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_mode,
  input  logic [WIDTH-1:0] in_operand_a,
  input  logic [WIDTH-1:0] in_operand_b,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_is_signed,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_result,
  output logic [1:0]       out_error
);
  localparam int W = WIDTH;
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic is_signed_r;
  logic [W:0]           v_c;
  logic [1:0]           mode_c [W+1];
  logic                 sgn_c [W+1];
  logic [W-1:0]         a_c [W+1];
  logic [W-1:0]         b_c [W+1];
  logic [W-1:0]         ma_c [W+1];
  logic [W-1:0]         mb_c [W+1];
  logic [2*W-1:0]       acc_c [W+1];
  logic [W-1:0]         rem_c [W+1];

  logic                 v_r;
  logic [1:0]           mode_r;
  logic                 sgn_r;
  logic [W-1:0]         a_r, b_r, ma_r, mb_r;
  logic [W-1:0]         ma_nxt, mb_nxt;
  logic                 ov_valid_r;
  logic [W-1:0]         ov_result_r, ov_result_nxt;
  logic [1:0]           ov_error_r, ov_error_nxt;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) is_signed_r <= 1'b1;
    else if (cfg_valid) is_signed_r <= cfg_is_signed;
  end

  // magnitudes for signed multiply/divide
  always_comb begin
    ma_nxt = in_operand_a;
    mb_nxt = in_operand_b;
    if (is_signed_r && (in_mode == MODE_MUL || in_mode == MODE_DIV)) begin
      if (in_operand_a[W-1]) ma_nxt = -in_operand_a;
      if (in_operand_b[W-1]) mb_nxt = -in_operand_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= start;
    mode_r <= in_mode;
    sgn_r <= is_signed_r;
    a_r <= in_operand_a;
    b_r <= in_operand_b;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
  end

  assign v_c[0] = v_r;
  assign mode_c[0] = mode_r;
  assign sgn_c[0] = sgn_r;
  assign a_c[0] = a_r;
  assign b_c[0] = b_r;
  assign ma_c[0] = ma_r;
  assign mb_c[0] = mb_r;
  assign acc_c[0] = '0;
  assign rem_c[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    cia_cell #(.W(W), .IDX(i)) u_cell (
      .clk, .rst_n,
      .v_i(v_c[i]), .mode_i(mode_c[i]), .sgn_i(sgn_c[i]),
      .a_i(a_c[i]), .b_i(b_c[i]), .ma_i(ma_c[i]), .mb_i(mb_c[i]),
      .acc_i(acc_c[i]), .rem_i(rem_c[i]),
      .v_o(v_c[i+1]), .mode_o(mode_c[i+1]), .sgn_o(sgn_c[i+1]),
      .a_o(a_c[i+1]), .b_o(b_c[i+1]), .ma_o(ma_c[i+1]), .mb_o(mb_c[i+1]),
      .acc_o(acc_c[i+1]), .rem_o(rem_c[i+1])
    );
  end

  logic [W-1:0]   fa, fb, sum, dif, lo, q;
  logic [W-1:0]   hi;
  logic           fs, neg;
  logic [1:0]     fm;

  always_comb begin
    fa = a_c[W];
    fb = b_c[W];
    fs = sgn_c[W];
    fm = mode_c[W];
    sum = fa + fb;
    dif = fa - fb;
    {hi, lo} = acc_c[W];
    q = acc_c[W][W-1:0];
    neg = fa[W-1] ^ fb[W-1];
    ov_error_nxt = ERR_OK;
    ov_result_nxt = '0;
    unique case (fm)
      MODE_ADD: begin
        ov_result_nxt = sum;
        if (fs) begin
          if (fa[W-1] == fb[W-1] && sum[W-1] != fa[W-1]) ov_error_nxt = ERR_OVERFLOW;
        end else if (sum < fa) ov_error_nxt = ERR_OVERFLOW;
      end
      MODE_SUB: begin
        ov_result_nxt = dif;
        if (fs) begin
          if (fa[W-1] != fb[W-1] && dif[W-1] != fa[W-1]) ov_error_nxt = ERR_OVERFLOW;
        end else if (fb > fa) ov_error_nxt = ERR_OVERFLOW;
      end
      MODE_MUL: begin
        if (fs) begin
          ov_result_nxt = neg ? -lo : lo;
          if (hi != '0 || (neg ? lo > SMIN : lo[W-1])) ov_error_nxt = ERR_OVERFLOW;
        end else begin
          ov_result_nxt = lo;
          if (hi != '0) ov_error_nxt = ERR_OVERFLOW;
        end
      end
      default: begin
        if (fb == '0) ov_error_nxt = ERR_DIV_ZERO;
        else if (fs && fa == SMIN && fb == '1) ov_error_nxt = ERR_OVERFLOW;
        else ov_result_nxt = (fs && neg) ? -q : q;
      end
    endcase
    if (ov_error_nxt != ERR_OK) ov_result_nxt = fa;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_valid_r <= 1'b0;
    else ov_valid_r <= v_c[W];
    ov_result_r <= ov_result_nxt;
    ov_error_r <= ov_error_nxt;
  end

  assign out_valid = ov_valid_r;
  assign out_result = ov_result_r;
  assign out_error = ov_error_r;
endmodule
